// File: rtl/core/ffha_pkg.sv
// shared types and constants of the first-fit heap allocator
package ffha_pkg;

  localparam int DATA_W            = 32;
  localparam int DEF_MAX_SEGMENTS  = 64;
  localparam int DEF_HEADER_BYTES  = 16;
  localparam int DEF_ADDR_BITS     = 32;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_BADADR = 2'd2
  } status_e;

  typedef enum logic {
    CFG_BASE = 1'b0,
    CFG_SIZE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic              command;
    logic [DATA_W-1:0] request_size;
    logic [DATA_W-1:0] block_address;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] granted_address;
  } rsp_t;

  // one table entry
  typedef struct packed {
    logic [DATA_W-1:0] off;
    logic [DATA_W-1:0] len;
    logic              used;
  } seg_t;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_FETCH = 11'b00000000010,
    S_EVAL  = 11'b00000000100,
    S_NXRD  = 11'b00000001000,
    S_NXEV  = 11'b00000010000,
    S_PREP  = 11'b00000100000,
    S_MERGE = 11'b00001000000,
    S_SHRD  = 11'b00010000000,
    S_SHWR  = 11'b00100000000,
    S_HEAD  = 11'b01000000000,
    S_TAIL  = 11'b10000000000
  } state_e;

  typedef struct packed {
    logic    start;
    logic    rd_idx;
    logic    rd_next;
    logic    rd_mv;
    logic    step;
    logic    cap_cur;
    logic    cap_next;
    logic    mv_top;
    logic    merge;
    logic    wr_mv;
    logic    wr_head;
    logic    wr_tail;
    logic    cnt_sub;
    logic    emit;
    logic    grant;
    status_e code;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
    logic empty;
    logic split;
    logic mv_more;
    logic is_rel;
  } dp_stat_t;

endpackage

// File: rtl/core/ffha_ctrl.sv
// sequencer of the allocator: search, shift and merge steps
module ffha_ctrl import ffha_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     command_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o   = '0;
    cmd_o.code = ST_OK;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.start = 1'b1;
          if (stat_i.empty) begin
            cmd_o.emit = 1'b1;
            cmd_o.code = (command_i == CMD_RELEASE) ? ST_BADADR : ST_NOFIT;
          end else begin
            state_d = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd_o.rd_idx = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (stat_i.hit) begin
          cmd_o.cap_cur = 1'b1;
          if (!stat_i.is_rel) begin
            state_d = S_PREP;
          end else if (!stat_i.last) begin
            state_d = S_NXRD;
          end else begin
            state_d = S_MERGE;
          end
        end else if (stat_i.last) begin
          cmd_o.emit = 1'b1;
          cmd_o.code = stat_i.is_rel ? ST_BADADR : ST_NOFIT;
          state_d = S_IDLE;
        end else begin
          cmd_o.step = 1'b1;
          state_d = S_FETCH;
        end
      end
      S_NXRD: begin
        cmd_o.rd_next = 1'b1;
        state_d = S_NXEV;
      end
      S_NXEV: begin
        cmd_o.cap_next = 1'b1;
        state_d = S_MERGE;
      end
      S_PREP: begin
        cmd_o.mv_top = 1'b1;
        state_d = stat_i.split ? S_SHRD : S_HEAD;
      end
      S_MERGE: begin
        cmd_o.merge = 1'b1;
        state_d = S_SHRD;
      end
      S_SHRD: begin
        if (stat_i.mv_more) begin
          cmd_o.rd_mv = 1'b1;
          state_d = S_SHWR;
        end else if (!stat_i.is_rel) begin
          state_d = S_HEAD;
        end else begin
          cmd_o.cnt_sub = 1'b1;
          cmd_o.emit = 1'b1;
          cmd_o.code = ST_OK;
          state_d = S_IDLE;
        end
      end
      S_SHWR: begin
        cmd_o.wr_mv = 1'b1;
        state_d = S_SHRD;
      end
      S_HEAD: begin
        cmd_o.wr_head = 1'b1;
        if (stat_i.split) begin
          state_d = S_TAIL;
        end else begin
          cmd_o.emit = 1'b1;
          cmd_o.grant = 1'b1;
          cmd_o.code = ST_OK;
          state_d = S_IDLE;
        end
      end
      S_TAIL: begin
        cmd_o.wr_tail = 1'b1;
        cmd_o.emit = 1'b1;
        cmd_o.grant = 1'b1;
        cmd_o.code = ST_OK;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/ffha_dpath.sv
// segment table memory, arena registers and result register
module ffha_dpath import ffha_pkg::*; #(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES,
  parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  req_t              req_i,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [DATA_W-1:0] cfg_data_i,
  input  dp_cmd_t           cmd_i,
  output dp_stat_t          stat_o,
  output logic              done_o,
  output rsp_t              rsp_o
);

  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam logic [DATA_W-1:0] HDR = DATA_W'(HEADER_BYTES);
  localparam logic [DATA_W-1:0] AMASK =
    (ADDR_BITS >= DATA_W) ? '1 : DATA_W'((64'd1 << ADDR_BITS) - 64'd1);

  seg_t mem [MAX_SEGMENTS];
  seg_t rd_q, cur_q, prev_q, next_q;

  logic [DATA_W-1:0] base_q, size_q, req_q, addr_q;
  logic              rel_q;
  logic [CNT_W-1:0]  count_q, mv_q;
  logic [IDX_W-1:0]  idx_q;
  logic [1:0]        rm_q;

  logic              done_q;
  rsp_t              rsp_q;

  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  seg_t              wdata;

  function automatic logic [DATA_W-1:0] seg_addr(input logic [DATA_W-1:0] base,
                                                 input logic [DATA_W-1:0] off);
    seg_addr = (base + off + HDR) & AMASK;
  endfunction

  // config rebuild
  logic [DATA_W-1:0] new_size;
  assign new_size = (cfg_index_i == CFG_SIZE) ? cfg_data_i : size_q;

  // merge on release
  logic             pm, nm;
  logic [IDX_W-1:0] tgt;
  logic [1:0]       rm;
  seg_t             merged;
  logic [DATA_W-1:0] len_pre, len_post;

  assign pm = (idx_q != '0) && !prev_q.used;
  assign nm = ((CNT_W'(idx_q) + CNT_W'(1)) < count_q) && !next_q.used;
  assign tgt = pm ? (idx_q - IDX_W'(1)) : idx_q;
  assign rm = {1'b0, pm} + {1'b0, nm};
  assign len_pre  = pm ? (prev_q.len + HDR) : '0;
  assign len_post = nm ? (next_q.len + HDR) : '0;
  always_comb begin
    merged.off  = pm ? prev_q.off : cur_q.off;
    merged.len  = len_pre + cur_q.len + len_post;
    merged.used = 1'b0;
  end

  // status toward the sequencer
  logic [DATA_W+1:0] need;
  assign need = {2'b00, req_q} + (DATA_W+2)'(HEADER_BYTES) + (DATA_W+2)'(1);

  always_comb begin
    stat_o.is_rel = rel_q;
    stat_o.empty  = (count_q == '0);
    stat_o.last   = (CNT_W'(idx_q) + CNT_W'(1)) >= count_q;
    stat_o.hit    = rel_q ? (rd_q.used && (seg_addr(base_q, rd_q.off) == addr_q))
                          : (!rd_q.used && (rd_q.len > req_q));
    stat_o.split  = ({2'b00, cur_q.len} >= need) &&
                    (count_q < CNT_W'(MAX_SEGMENTS));
    stat_o.mv_more = rel_q ? (mv_q < count_q) : (mv_q > CNT_W'(idx_q));
  end

  // memory ports
  always_comb begin
    raddr = idx_q;
    if (cmd_i.rd_next) begin
      raddr = idx_q + IDX_W'(1);
    end else if (cmd_i.rd_mv) begin
      raddr = mv_q[IDX_W-1:0];
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cfg_we_i) begin
      we         = (new_size >= HDR);
      wdata.len  = new_size - HDR;
    end else if (cmd_i.wr_mv) begin
      we    = 1'b1;
      wdata = rd_q;
      waddr = rel_q ? IDX_W'(mv_q - CNT_W'(rm_q)) : IDX_W'(mv_q + CNT_W'(1));
    end else if (cmd_i.wr_head) begin
      we         = 1'b1;
      waddr      = idx_q;
      wdata.off  = cur_q.off;
      wdata.len  = stat_o.split ? req_q : cur_q.len;
      wdata.used = 1'b1;
    end else if (cmd_i.wr_tail) begin
      we        = 1'b1;
      waddr     = idx_q + IDX_W'(1);
      wdata.off = cur_q.off + HDR + req_q;
      wdata.len = cur_q.len - req_q - HDR;
    end else if (cmd_i.merge) begin
      we    = 1'b1;
      waddr = tgt;
      wdata = merged;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q  <= req_i.request_size;
      addr_q <= req_i.block_address;
      rel_q  <= req_i.command;
    end
    if (cmd_i.cap_cur) begin
      cur_q <= rd_q;
    end
    if (cmd_i.step) begin
      prev_q <= rd_q;
    end
    if (cmd_i.cap_next) begin
      next_q <= rd_q;
    end
    if (cmd_i.merge) begin
      rm_q <= rm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      size_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
      mv_q    <= '0;
      done_q  <= 1'b0;
      rsp_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_BASE) begin
          base_q <= cfg_data_i;
        end else begin
          size_q <= cfg_data_i;
        end
        count_q <= (new_size >= HDR) ? CNT_W'(1) : '0;
      end
      if (cmd_i.start) begin
        idx_q <= '0;
      end else if (cmd_i.step) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (cmd_i.mv_top) begin
        mv_q <= count_q - CNT_W'(1);
      end else if (cmd_i.merge) begin
        mv_q <= CNT_W'(tgt) + CNT_W'(1) + CNT_W'(rm);
      end else if (cmd_i.wr_mv) begin
        mv_q <= rel_q ? (mv_q + CNT_W'(1)) : (mv_q - CNT_W'(1));
      end
      if (cmd_i.wr_tail) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cmd_i.cnt_sub) begin
        count_q <= count_q - CNT_W'(rm_q);
      end
      done_q <= cmd_i.emit;
      if (cmd_i.emit) begin
        rsp_q.status          <= cmd_i.code;
        rsp_q.granted_address <= cmd_i.grant ? seg_addr(base_q, cur_q.off) : '0;
      end
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// File: rtl/core/first_fit_heap_allocator_unit.sv
// top level of the first-fit heap allocator with coalescing
//
// A command word is taken at a clock edge with start high and busy low;
// unless the table is empty, busy then stays high until the answer is
// issued. Each answer appears on rsp_o for exactly one cycle with done_o
// high; the receiver cannot stall. Allocate walks the segment table from
// entry 0 (a synchronous memory read, then a compare per entry), then on
// a split moves the entries above the hit up by one, reading and writing
// each, before writing the granted and the new free entry. Release walks
// the same way, reads the following neighbor unless the hit is last,
// writes the merged entry and moves the entries behind it down. An empty
// table is answered in the cycle after the command is taken. The arena
// registers are written on the cfg channel while busy is low; a write
// rebuilds the table as one free segment (none if size is below the header)
// in the same cycle. Reset clears the arena and result registers and empties the table.
module first_fit_heap_allocator_unit import ffha_pkg::*; #(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES,
  parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  req_t              req_i,
  output logic              done_o,
  output rsp_t              rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [DATA_W-1:0] cfg_data_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = !busy;

  ffha_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .command_i (req_i.command),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .busy_o    (busy)
  );

  ffha_dpath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .HEADER_BYTES (HEADER_BYTES),
    .ADDR_BITS    (ADDR_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

  // answers are only issued once the sequencer is back at rest
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("answer issued while busy");

  // a failed request never carries an address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != ST_OK) |-> (rsp_o.granted_address == '0))
    else $error("failure answer with nonzero address");

  // a granted answer follows a busy phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.granted_address != '0) |-> $past(busy, 2))
    else $error("grant without table walk");

endmodule
